// File: rtl/rpe_pkg.sv
// ----------------------------------------------------------------------------
// rpe_pkg: shared definitions for the postfix expression evaluator
// Token codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  // Token codes carried on the input tuser field.
  localparam logic [4:0] ACT_PUSH = 5'd0;
  localparam logic [4:0] ACT_LNOT = 5'd1;
  localparam logic [4:0] ACT_INV  = 5'd2;
  localparam logic [4:0] ACT_ADD  = 5'd3;
  localparam logic [4:0] ACT_SUB  = 5'd4;
  localparam logic [4:0] ACT_MUL  = 5'd5;
  localparam logic [4:0] ACT_DIV  = 5'd6;
  localparam logic [4:0] ACT_MOD  = 5'd7;
  localparam logic [4:0] ACT_AND  = 5'd8;
  localparam logic [4:0] ACT_OR   = 5'd9;
  localparam logic [4:0] ACT_XOR  = 5'd10;
  localparam logic [4:0] ACT_SHR  = 5'd11;
  localparam logic [4:0] ACT_SHL  = 5'd12;
  localparam logic [4:0] ACT_NE   = 5'd13;
  localparam logic [4:0] ACT_EQ   = 5'd14;
  localparam logic [4:0] ACT_LE   = 5'd15;
  localparam logic [4:0] ACT_GE   = 5'd16;
  localparam logic [4:0] ACT_LOR  = 5'd17;
  localparam logic [4:0] ACT_LAND = 5'd18;
  localparam logic [4:0] ACT_LT   = 5'd19;
  localparam logic [4:0] ACT_GT   = 5'd20;
  localparam logic [4:0] ACT_END  = 5'd21;

  // Operand width and divider step counter width.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIV_CNT_W = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic disp;      // execute push, unary, end, or start a binary read
    logic alu;       // write the combinational ALU binary result
    logic div_init;  // load the divider
    logic div_step;  // one restoring division step
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_binary;
    logic is_divmod;
    logic is_end;
    logic bin_ok;    // at least two entries on the stack
    logic div_zero;  // right operand is zero
    logic div_last;  // final division step
    logic out_busy;  // output register holds a result that is not taken
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: postfix token evaluator on a 32-bit stack
//
// Input channel: one request per token; in_tuser carries the token code and
// in_tdata the pushed value (ignored for operators). Output channel: one
// request per end token with the top of stack on out_tdata and an error
// flag on out_tuser.
// Sequencing: push, unary, end and ignored tokens need only the dispatch
// state; binary operators add an execute state that uses the second entry
// read from the stack RAM, and divide and modulo then run 32 steps of the
// restoring divider unless the divisor is zero. One token is in work at a
// time. An end token is written to the output register at its dispatch,
// which waits until that register is free.
// The output register is separate from the core, so tokens keep flowing
// while a result waits; only a second end token waits for it to be taken.
// Reset empties the stack, clears the error flag and drops any pending
// result; the stack RAM itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand
  input  wire logic [4:0]  in_tuser,   // [4:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] result_value
  output logic [0:0]       out_tuser   // [0] eval_error
);

  rpe_pkg::ctrl_cmd_t cmd;
  rpe_pkg::dp_stat_t  stat;
  logic               out_error;

  rpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpe_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser),
    .in_operand (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_error  (out_error)
  );

  assign out_tuser = out_error;

endmodule

`default_nettype wire

// File: rtl/rpe_ram.sv
// ----------------------------------------------------------------------------
// rpe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rpe_ctrl.sv
// ----------------------------------------------------------------------------
// rpe_ctrl: sequencer for the postfix expression evaluator
// Accepts one request at a time and steps the datapath through dispatch,
// operand read, execution and iterative division.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire rpe_pkg::dp_stat_t  stat,
  output rpe_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        // An end token waits until the output register is free.
        if (!(stat.is_end && stat.out_busy)) begin
          cmd.disp = 1'b1;
          if (stat.is_binary && stat.bin_ok) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EXEC: begin
        if (stat.is_divmod && !stat.div_zero) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.alu   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rpe_dp.sv
// ----------------------------------------------------------------------------
// rpe_dp: datapath of the postfix expression evaluator
// Top of stack in a register, lower entries in RAM, combinational ALU,
// radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_dp #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [4:0]         in_action,
  input  wire logic [31:0]        in_operand,
  input  wire rpe_pkg::ctrl_cmd_t cmd,
  output rpe_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_value,
  output logic                    out_error
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned XW = rpe_pkg::DATA_W;
  localparam int unsigned CW = rpe_pkg::DIV_CNT_W;

  // Latched request.
  logic [4:0]    act_r;
  logic [XW-1:0] opd_r;

  // Stack state.
  logic [XW-1:0] tos_r,    tos_nxt;
  logic [DW-1:0] depth_r,  depth_nxt;
  logic          sticky_r, sticky_nxt;

  // Divider state.
  logic [XW-1:0] quo_r, quo_nxt;
  logic [XW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [XW-1:0] out_value_r;
  logic          out_error_r;

  // Decode and stack bookkeeping.
  logic          is_push, is_unary, is_binary, is_divmod, is_end;
  logic [DW-1:0] depth_m1, depth_m2;
  logic          full, empty;
  logic          ram_wr, ram_rd;
  logic [XW-1:0] ram_rdata;
  logic [XW-1:0] op_a, alu_res;
  logic          emit;

  // Divider step.
  logic [XW:0]   rem_sh, rem_diff;
  logic          rem_ge;
  logic [XW-1:0] step_quo, step_rem;

  assign is_push   = (act_r == rpe_pkg::ACT_PUSH);
  assign is_unary  = (act_r == rpe_pkg::ACT_LNOT) || (act_r == rpe_pkg::ACT_INV);
  assign is_binary = act_r inside {[rpe_pkg::ACT_ADD:rpe_pkg::ACT_GT]};
  assign is_divmod = (act_r == rpe_pkg::ACT_DIV) || (act_r == rpe_pkg::ACT_MOD);
  assign is_end    = (act_r == rpe_pkg::ACT_END);

  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);
  assign full     = (depth_r >= DW'(STACK_DEPTH));
  assign empty    = (depth_r == '0);

  // The old top moves into RAM on a push; the second entry is read for binaries.
  assign ram_wr = cmd.disp && is_push && !full && !empty;
  assign ram_rd = cmd.disp && is_binary && stat.bin_ok;
  assign emit   = cmd.disp && is_end;

  rpe_ram #(
    .WIDTH (XW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (depth_m1[AW-1:0]),
    .wr_data (tos_r),
    .rd_en   (ram_rd),
    .rd_addr (depth_m2[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign op_a = ram_rdata;

  // Combinational binary operators; divide and modulo here only cover a zero divisor.
  always_comb begin
    case (act_r)
      rpe_pkg::ACT_ADD:  alu_res = op_a + tos_r;
      rpe_pkg::ACT_SUB:  alu_res = op_a - tos_r;
      rpe_pkg::ACT_MUL:  alu_res = op_a * tos_r;
      rpe_pkg::ACT_AND:  alu_res = op_a & tos_r;
      rpe_pkg::ACT_OR:   alu_res = op_a | tos_r;
      rpe_pkg::ACT_XOR:  alu_res = op_a ^ tos_r;
      rpe_pkg::ACT_SHR:  alu_res = (tos_r < XW'(32)) ? (op_a >> tos_r[4:0]) : '0;
      rpe_pkg::ACT_SHL:  alu_res = (tos_r < XW'(32)) ? (op_a << tos_r[4:0]) : '0;
      rpe_pkg::ACT_NE:   alu_res = XW'(op_a != tos_r);
      rpe_pkg::ACT_EQ:   alu_res = XW'(op_a == tos_r);
      rpe_pkg::ACT_LE:   alu_res = XW'(op_a <= tos_r);
      rpe_pkg::ACT_GE:   alu_res = XW'(op_a >= tos_r);
      rpe_pkg::ACT_LOR:  alu_res = XW'((op_a != '0) || (tos_r != '0));
      rpe_pkg::ACT_LAND: alu_res = XW'((op_a != '0) && (tos_r != '0));
      rpe_pkg::ACT_LT:   alu_res = XW'(op_a < tos_r);
      rpe_pkg::ACT_GT:   alu_res = XW'(op_a > tos_r);
      default:           alu_res = op_a;
    endcase
  end

  // One restoring division step against the divisor held in the top register.
  assign rem_sh   = {rem_r, quo_r[XW-1]};
  assign rem_diff = rem_sh - {1'b0, tos_r};
  assign rem_ge   = !rem_diff[XW];
  assign step_rem = rem_ge ? rem_diff[XW-1:0] : rem_sh[XW-1:0];
  assign step_quo = {quo_r[XW-2:0], rem_ge};

  // Stack, divider and output next-state logic.
  always_comb begin
    tos_nxt       = tos_r;
    depth_nxt     = depth_r;
    sticky_nxt    = sticky_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.disp) begin
      if (is_push) begin
        if (full) begin
          sticky_nxt = 1'b1;
        end else begin
          tos_nxt   = opd_r;
          depth_nxt = depth_r + DW'(1);
        end
      end else if (is_unary) begin
        if (empty) begin
          sticky_nxt = 1'b1;
        end else if (act_r == rpe_pkg::ACT_LNOT) begin
          tos_nxt = XW'(tos_r == '0);
        end else begin
          tos_nxt = ~tos_r;
        end
      end else if (is_binary) begin
        if (!stat.bin_ok) begin
          sticky_nxt = 1'b1;
        end
      end else if (is_end) begin
        out_valid_nxt = 1'b1;
        depth_nxt     = '0;
        sticky_nxt    = 1'b0;
      end
    end

    if (cmd.alu) begin
      tos_nxt   = alu_res;
      depth_nxt = depth_m1;
    end

    if (cmd.div_init) begin
      quo_nxt = op_a;
      rem_nxt = '0;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      quo_nxt = step_quo;
      rem_nxt = step_rem;
      cnt_nxt = cnt_r + CW'(1);
      if (stat.div_last) begin
        tos_nxt   = (act_r == rpe_pkg::ACT_MOD) ? step_rem : step_quo;
        depth_nxt = depth_m1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      opd_r <= in_operand;
    end
    if (emit) begin
      out_value_r <= empty ? '0 : tos_r;
      out_error_r <= sticky_r || (depth_r != DW'(1));
    end
    tos_r <= tos_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  // Status to the controller.
  always_comb begin
    stat.is_binary = is_binary;
    stat.is_divmod = is_divmod;
    stat.is_end    = is_end;
    stat.bin_ok    = (depth_r >= DW'(2));
    stat.div_zero  = (tos_r == '0);
    stat.div_last  = (cnt_r == {CW{1'b1}});
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  // The stack never grows past its configured depth.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth exceeds capacity");

  // An end token leaves an empty stack and a clear sticky error.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (depth_r == '0) && !sticky_r && out_valid_r)
    else $error("end token did not reset the stack");

  // The divider is never started with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> (tos_r != '0))
    else $error("divider started with zero divisor");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the postfix expression evaluator
// Drives token streams (directed special cases, well-formed expressions with
// random content, broken sequences, noise and deep stack overflows) and
// checks every end-token result against an internal stack predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_N     = 64;
  localparam int unsigned ITEM_TARGET = 1100;
  // Longest legal quiet stretch is the long receiver hold plus a divide and
  // the stalls around them; take that several times over.
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 64;
  // Lowest and highest of the token codes that the block ignores.
  localparam logic [4:0] ACT_IGNORED_LO = 5'd22;
  localparam logic [4:0] ACT_IGNORED_HI = 5'd31;

  // Stack predictor and store of expected end-token results.
  class expr_scoreboard;
    typedef struct {
      logic [31:0] value;
      logic        err;
    } outcome_t;

    logic [31:0] stack_mem [STACK_N];
    int unsigned depth;
    bit          sticky;
    outcome_t    expected_results [$];
    int          errors;
    int          results_seen;

    function new();
      depth = 0;
      sticky = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    // Two-operand result, a is the lower entry and b the top.
    function logic [31:0] combine(logic [4:0] act, logic [31:0] a, logic [31:0] b);
      case (act)
        rpe_pkg::ACT_ADD:  return a + b;
        rpe_pkg::ACT_SUB:  return a - b;
        rpe_pkg::ACT_MUL:  return a * b;
        rpe_pkg::ACT_DIV:  return (b != 0) ? a / b : a;
        rpe_pkg::ACT_MOD:  return (b != 0) ? a % b : a;
        rpe_pkg::ACT_AND:  return a & b;
        rpe_pkg::ACT_OR:   return a | b;
        rpe_pkg::ACT_XOR:  return a ^ b;
        rpe_pkg::ACT_SHR:  return (b < 32) ? a >> b[4:0] : 32'd0;
        rpe_pkg::ACT_SHL:  return (b < 32) ? a << b[4:0] : 32'd0;
        rpe_pkg::ACT_NE:   return (a != b) ? 32'd1 : 32'd0;
        rpe_pkg::ACT_EQ:   return (a == b) ? 32'd1 : 32'd0;
        rpe_pkg::ACT_LE:   return (a <= b) ? 32'd1 : 32'd0;
        rpe_pkg::ACT_GE:   return (a >= b) ? 32'd1 : 32'd0;
        rpe_pkg::ACT_LOR:  return (a != 0 || b != 0) ? 32'd1 : 32'd0;
        rpe_pkg::ACT_LAND: return (a != 0 && b != 0) ? 32'd1 : 32'd0;
        rpe_pkg::ACT_LT:   return (a < b) ? 32'd1 : 32'd0;
        default:           return (a > b) ? 32'd1 : 32'd0;
      endcase
    endfunction

    // Update the predicted stack for one accepted token.
    function void note_token(logic [4:0] act, logic [31:0] opnd);
      outcome_t    o;
      logic [31:0] t;
      if (act == rpe_pkg::ACT_PUSH) begin
        if (depth >= STACK_N) begin
          sticky = 1;
        end else begin
          stack_mem[depth] = opnd;
          depth++;
        end
      end else if (act == rpe_pkg::ACT_LNOT || act == rpe_pkg::ACT_INV) begin
        if (depth == 0) begin
          sticky = 1;
        end else begin
          t = stack_mem[depth-1];
          stack_mem[depth-1] = (act == rpe_pkg::ACT_LNOT) ? ((t == 0) ? 32'd1 : 32'd0) : ~t;
        end
      end else if (act < rpe_pkg::ACT_END) begin
        if (depth < 2) begin
          sticky = 1;
        end else begin
          stack_mem[depth-2] = combine(act, stack_mem[depth-2], stack_mem[depth-1]);
          depth--;
        end
      end else if (act == rpe_pkg::ACT_END) begin
        o.value = (depth > 0) ? stack_mem[depth-1] : 32'd0;
        o.err = sticky || (depth != 1);
        expected_results.push_back(o);
        depth = 0;
        sticky = 0;
      end
      // Codes above the end token leave everything unchanged.
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [31:0] value, logic err);
      outcome_t o;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected: value=%h error=%b", value, err));
      end else begin
        o = expected_results.pop_front();
        if (value !== o.value)
          report($sformatf("result value %h, expected %h", value, o.value));
        if (err !== o.err)
          report($sformatf("error flag %b, expected %b", err, o.err));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [4:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  expr_scoreboard expr_check;
  int unsigned    items_sent;
  int unsigned    burst_left;
  int unsigned    idle_cycles;

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_N)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly corner values, so that shifts, divides and compares hit edges.
  function logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 40);
      3:       return 32'd1;
      4:       return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function logic [4:0] pick_binary();
    return 5'($urandom_range(rpe_pkg::ACT_ADD, rpe_pkg::ACT_GT));
  endfunction

  // Offer one token; the sender works in bursts separated by idle gaps.
  task send_token(logic [4:0] act, logic [31:0] opnd);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = act;
    in_tdata = opnd;
    do @(posedge clk); while (!in_tready);
    if (act <= rpe_pkg::ACT_END) items_sent++;
  endtask

  // Stop offering and wait until every expected result has been taken.
  task drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expr_check.expected_results.size() != 0) @(negedge clk);
  endtask

  // A random expression. A broken one skips part of the final reduction
  // or starts with an operator on a short stack.
  task run_expression(bit intact);
    int unsigned d;
    int unsigned stop_at;
    d = 0;
    if (!intact && $urandom_range(0, 1) == 1) send_token(pick_binary(), pick_operand());
    repeat ($urandom_range(1, 12)) begin
      if (d < 2 || $urandom_range(0, 2) == 0) begin
        send_token(rpe_pkg::ACT_PUSH, pick_operand());
        d++;
      end else if ($urandom_range(0, 4) == 0) begin
        send_token(($urandom_range(0, 1) == 1) ? rpe_pkg::ACT_LNOT : rpe_pkg::ACT_INV,
                   pick_operand());
      end else begin
        send_token(pick_binary(), pick_operand());
        d--;
      end
    end
    stop_at = intact ? 1 : $urandom_range(0, 3);
    while (d > stop_at && d > 1) begin
      send_token(pick_binary(), pick_operand());
      d--;
    end
    if (intact && d == 0) send_token(rpe_pkg::ACT_PUSH, pick_operand());
    send_token(rpe_pkg::ACT_END, pick_operand());
  endtask

  // Fill the stack to the top (and past it by extra), reduce to one entry.
  task run_overflow(int unsigned extra);
    repeat (STACK_N + extra) send_token(rpe_pkg::ACT_PUSH, pick_operand());
    repeat (STACK_N - 1) send_token(pick_binary(), pick_operand());
    send_token(rpe_pkg::ACT_END, pick_operand());
  endtask

  // Monitors: note accepted tokens and check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      expr_check.note_token(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      expr_check.check_result(out_tdata, out_tuser[0]);
  end

  // Watchdog on cycles without any request moving.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("postfix_expression_evaluator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: rotating stall patterns, plus one long hold while the
  // sender keeps going, so a second end token backs up the input.
  initial begin : receiver
    int unsigned rx_cycle;
    bit          hold_done;
    rx_cycle = 0;
    hold_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (!hold_done && expr_check.results_seen >= 20) begin
        hold_done = 1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        case ((rx_cycle / 300) % 3)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 1) == 1);
          default: out_tready = ((rx_cycle % 7) < 2);
        endcase
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int unsigned pick;
    bit          paused;
    expr_check = new();
    items_sent = 0;
    burst_left = 0;
    idle_cycles = 0;
    paused = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 32'd0;
    in_tuser = rpe_pkg::ACT_PUSH;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // End on an empty stack, unary and binary underflow, ignored codes.
    send_token(rpe_pkg::ACT_END, 32'd0);
    send_token(rpe_pkg::ACT_LNOT, 32'hFFFF_FFFF);
    send_token(rpe_pkg::ACT_END, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'hFFFF_FFFF);
    send_token(rpe_pkg::ACT_SUB, 32'd0);
    send_token(rpe_pkg::ACT_END, 32'd0);
    send_token(ACT_IGNORED_HI, 32'hFFFF_FFFF);
    send_token(ACT_IGNORED_LO, 32'd0);

    // Unary ops, divide and modulo by zero, shifts by 32 and more.
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_LNOT, 32'd0);
    send_token(rpe_pkg::ACT_INV, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_DIV, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_MOD, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd32);
    send_token(rpe_pkg::ACT_SHL, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'hFFFF_FFFF);
    send_token(rpe_pkg::ACT_OR, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd40);
    send_token(rpe_pkg::ACT_SHR, 32'd0);
    send_token(rpe_pkg::ACT_END, 32'd0);

    // One chain through the remaining operators at wrap-around values.
    send_token(rpe_pkg::ACT_PUSH, 32'hFFFF_FFFF);
    send_token(rpe_pkg::ACT_PUSH, 32'd1);
    send_token(rpe_pkg::ACT_ADD, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd1);
    send_token(rpe_pkg::ACT_SUB, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'hFFFF_FFFF);
    send_token(rpe_pkg::ACT_MUL, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'h0000_FFFF);
    send_token(rpe_pkg::ACT_AND, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'h8000_0001);
    send_token(rpe_pkg::ACT_XOR, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'h8000_0000);
    send_token(rpe_pkg::ACT_NE, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_EQ, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd1);
    send_token(rpe_pkg::ACT_LE, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd2);
    send_token(rpe_pkg::ACT_GE, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_LOR, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd5);
    send_token(rpe_pkg::ACT_LAND, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_LT, 32'd0);
    send_token(rpe_pkg::ACT_PUSH, 32'd0);
    send_token(rpe_pkg::ACT_GT, 32'd0);
    send_token(rpe_pkg::ACT_END, 32'd0);

    // Push past a full stack, and fill it exactly.
    run_overflow(1);
    run_overflow(0);

    // Random part: mostly well-formed expressions, some broken ones,
    // some noise with ignored codes, and a rare deep overflow.
    while (items_sent < ITEM_TARGET) begin
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        paused = 1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        run_expression(1);
      end else if (pick < 88) begin
        run_expression(0);
      end else if (pick < 99) begin
        repeat ($urandom_range(1, 6)) send_token(5'($urandom_range(0, 31)), pick_operand());
        if ($urandom_range(0, 1) == 1) send_token(rpe_pkg::ACT_END, pick_operand());
      end else begin
        run_overflow($urandom_range(0, 2));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expr_check.errors == 0 && expr_check.expected_results.size() == 0) begin
      $display("postfix_expression_evaluator verification clean");
    end else begin
      $display("postfix_expression_evaluator verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/rpe_pkg.sv
rtl/rpe_ram.sv
rtl/rpe_ctrl.sv
rtl/rpe_dp.sv
rtl/postfix_expression_evaluator.sv
tb/sv/tb_top.sv
